@@ design/stream_prefetch_slot_table_defines.svh @@
// Assertion macros of the stream prefetch slot table design.
`ifndef STREAM_PREFETCH_SLOT_TABLE_DEFINES_SVH
`define STREAM_PREFETCH_SLOT_TABLE_DEFINES_SVH
`ifndef SYNTHESIS
// Concurrent check on every clock, off while in reset
`define SPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);
// Condition in one cycle implies a condition in the next cycle
`define SPS_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);
`else
`define SPS_ASSERT(lbl, prop, msg)
`define SPS_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

@@ design/sps_pkg.sv @@
// Types and codes of the stream prefetch slot table.
package sps_pkg;

	typedef logic [31:0] pos_t;
	typedef logic [23:0] len_t;
	typedef logic [2:0]  cmd_t;
	typedef logic [1:0]  sstate_t;
	typedef logic [1:0]  rstat_t;

	// command codes
	localparam cmd_t CMD_REQUEST   = 3'd0;
	localparam cmd_t CMD_LOAD_NEXT = 3'd1;
	localparam cmd_t CMD_GET       = 3'd2;
	localparam cmd_t CMD_FLUSH     = 3'd3;
	localparam cmd_t CMD_FLUSH_ALL = 3'd4;
	localparam cmd_t CMD_STATUS    = 3'd5;

	// slot states
	localparam sstate_t SL_FREE   = 2'd0;
	localparam sstate_t SL_WAIT   = 2'd1;
	localparam sstate_t SL_LOADED = 2'd2;

	// result status codes
	localparam rstat_t RS_OK       = 2'd0;
	localparam rstat_t RS_REJECT   = 2'd1;
	localparam rstat_t RS_NO_FREE  = 2'd2;
	localparam rstat_t RS_NO_MATCH = 2'd3;

	localparam len_t MAX_SIZE_RESET = 24'd65536;

	// outcome of checking one slot against the current command
	typedef struct packed {
		logic hit;
		len_t offset;
		len_t remain;
	} chk_t;

endpackage

@@ design/sps_req_if.sv @@
// Command channel of the stream prefetch slot table.
interface sps_req_if;
	import sps_pkg::*;
	logic  valid;
	logic  ready;
	cmd_t  cmd;
	pos_t  position;
	len_t  size;
	logic [2:0] slot_index;

	modport source(output valid, cmd, position, size, slot_index, input ready);
	modport sink(input valid, cmd, position, size, slot_index, output ready);
endinterface

@@ design/sps_rsp_if.sv @@
// Result channel of the stream prefetch slot table.
interface sps_rsp_if;
	import sps_pkg::*;
	logic   valid;
	logic   ready;
	rstat_t status;
	logic [2:0] slot;
	len_t   offset;
	len_t   length;
	pos_t   position_out;
	logic   clamped;

	modport source(output valid, status, slot, offset, length, position_out, clamped,
		input ready);
	modport sink(input valid, status, slot, offset, length, position_out, clamped,
		output ready);
endinterface

@@ design/stream_prefetch_slot_table.sv @@
// Stream prefetch slot table: top level with slot store and scan sequencer.
//
// Usage: commands enter on the req channel (valid/ready), one result per
// command leaves on the rsp channel (valid/ready). The size limit is set by
// a write on cfg_we/cfg_wdata while the block is idle.
// One command at a time: req.ready is high only when no command is in work
// and no result is pending.
// Path from accept to result valid:
//   rejected arguments, unknown code, flush_all: straight to the result;
//   status: reads just the asked slot;
//   request, load_next: scan that stops at the first match;
//   get: stops at the first match, then a final step; flush: every slot.
// The scan visits one slot per cycle through the single read port of the
// slot store and one shared compare unit.
// Reset: every slot free, size limit 65536; the slot store itself needs no
// clearing, since free slots are never read for their contents.
// A stalled receiver holds the result on rsp; no new command is taken until
// it is accepted.
`include "stream_prefetch_slot_table_defines.svh"
module stream_prefetch_slot_table #(
	parameter int SLOTS = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          cfg_we,
	input  sps_pkg::len_t cfg_wdata,
	sps_req_if.sink       req,
	sps_rsp_if.source     rsp
);
	import sps_pkg::*;

	localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W = $clog2(SLOTS + 1);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_FIN  = 4'b0100,
		S_RESP = 4'b1000
	} fsm_t;

	fsm_t             state_q;
	cmd_t             cmd_q;
	pos_t             pos_q;
	len_t             size_q;
	logic             clamped_q;
	len_t             max_q;
	logic             found_q;
	sstate_t          slot_st_q [SLOTS];
	pos_t             pos_mem [SLOTS];
	len_t             size_mem [SLOTS];
	logic [CNT_W-1:0] scan_q;
	logic             chk_vld_s1;
	logic [IDX_W-1:0] chk_idx_s1;
	pos_t             rd_pos_s1;
	len_t             rd_size_s1;

	rstat_t     res_status_q;
	logic [2:0] res_slot_q;
	len_t       res_offset_q;
	len_t       res_length_q;
	pos_t       res_pos_q;
	logic       res_clamped_q;

	chk_t chk;
	logic rd_en;
	logic stop_hit;
	logic finish;
	logic acc_reject;

	// handshake and result outputs
	assign req.ready        = (state_q == S_IDLE);
	assign rsp.valid        = (state_q == S_RESP);
	assign rsp.status       = res_status_q;
	assign rsp.slot         = res_slot_q;
	assign rsp.offset       = res_offset_q;
	assign rsp.length       = res_length_q;
	assign rsp.position_out = res_pos_q;
	assign rsp.clamped      = res_clamped_q;

	sps_slot_check u_check (
		.cmd       (cmd_q),
		.position  (pos_q),
		.st        (slot_st_q[chk_idx_s1]),
		.slot_pos  (rd_pos_s1),
		.slot_size (rd_size_s1),
		.res       (chk)
	);

	// argument check of the offered command
	always_comb begin
		case (req.cmd)
			CMD_REQUEST:   acc_reject = (req.size == '0) || (req.position == '0) ||
				(req.position == '1);
			CMD_LOAD_NEXT: acc_reject = 1'b0;
			CMD_GET:       acc_reject = (req.position == '0);
			CMD_FLUSH:     acc_reject = (req.position == '0) || (req.position == '1);
			CMD_FLUSH_ALL: acc_reject = 1'b0;
			CMD_STATUS:    acc_reject = (32'(req.slot_index) >= SLOTS);
			default:       acc_reject = 1'b1;
		endcase
	end

	// scan control: read one slot per cycle, check it in the cycle after
	always_comb begin
		stop_hit = chk_vld_s1 && chk.hit && (cmd_q != CMD_FLUSH);
		finish   = stop_hit || (chk_vld_s1 && ((chk_idx_s1 == IDX_W'(SLOTS - 1)) ||
			(cmd_q == CMD_STATUS)));
		rd_en    = (state_q == S_SCAN) && (scan_q < CNT_W'(SLOTS)) && !finish;
	end

	// size limit register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_q <= MAX_SIZE_RESET;
		end else if (cfg_we) begin
			max_q <= cfg_wdata;
		end
	end

	// slot store: written by request, read by the scan
	always_ff @(posedge clk) begin
		if (state_q == S_SCAN && stop_hit && cmd_q == CMD_REQUEST) begin
			pos_mem[chk_idx_s1]  <= pos_q;
			size_mem[chk_idx_s1] <= size_q;
		end
		if (rd_en) begin
			rd_pos_s1  <= pos_mem[scan_q[IDX_W-1:0]];
			rd_size_s1 <= size_mem[scan_q[IDX_W-1:0]];
		end
	end

	// command latch (payload)
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req.valid) begin
			cmd_q <= req.cmd;
			pos_q <= req.position;
			if (req.cmd == CMD_REQUEST && req.size > max_q) begin
				size_q    <= max_q;
				clamped_q <= 1'b1;
			end else begin
				size_q    <= req.size;
				clamped_q <= 1'b0;
			end
		end
	end

	// sequencer, slot states and result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			scan_q        <= '0;
			chk_vld_s1    <= 1'b0;
			chk_idx_s1    <= '0;
			found_q       <= 1'b0;
			res_status_q  <= RS_OK;
			res_slot_q    <= '0;
			res_offset_q  <= '0;
			res_length_q  <= '0;
			res_pos_q     <= '0;
			res_clamped_q <= 1'b0;
			for (int i = 0; i < SLOTS; i++) begin
				slot_st_q[i] <= SL_FREE;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					chk_vld_s1 <= 1'b0;
					found_q    <= 1'b0;
					// status reads just the asked slot
					scan_q     <= (req.cmd == CMD_STATUS && !acc_reject) ?
						CNT_W'(req.slot_index) : '0;
					if (req.valid) begin
						res_status_q  <= acc_reject ? RS_REJECT : RS_OK;
						res_slot_q    <= (req.cmd == CMD_STATUS) ? req.slot_index : 3'd0;
						res_offset_q  <= '0;
						res_length_q  <= '0;
						res_pos_q     <= '0;
						res_clamped_q <= 1'b0;
						if (acc_reject) begin
							state_q <= S_RESP;
						end else if (req.cmd == CMD_FLUSH_ALL) begin
							for (int i = 0; i < SLOTS; i++) begin
								slot_st_q[i] <= SL_FREE;
							end
							state_q <= S_RESP;
						end else begin
							state_q <= S_SCAN;
						end
					end
				end
				S_SCAN: begin
					chk_vld_s1 <= rd_en;
					chk_idx_s1 <= scan_q[IDX_W-1:0];
					if (rd_en) begin
						scan_q <= scan_q + CNT_W'(1);
					end
					// act on a matching slot
					if (chk_vld_s1 && chk.hit) begin
						case (cmd_q)
							CMD_REQUEST: begin
								slot_st_q[chk_idx_s1] <= SL_WAIT;
								res_slot_q    <= 3'(chk_idx_s1);
								res_length_q  <= size_q;
								res_clamped_q <= clamped_q;
							end
							CMD_LOAD_NEXT: begin
								slot_st_q[chk_idx_s1] <= SL_LOADED;
								res_slot_q   <= 3'(chk_idx_s1);
								res_length_q <= rd_size_s1;
								res_pos_q    <= rd_pos_s1;
							end
							CMD_GET: begin
								slot_st_q[chk_idx_s1] <= SL_FREE;
								res_slot_q   <= 3'(chk_idx_s1);
								res_offset_q <= chk.offset;
								res_length_q <= chk.remain;
							end
							CMD_FLUSH: begin
								slot_st_q[chk_idx_s1] <= SL_FREE;
								found_q <= 1'b1;
								if (!found_q) begin
									res_slot_q <= 3'(chk_idx_s1);
								end
							end
							CMD_STATUS: begin
								res_pos_q <= rd_pos_s1;
							end
							default: begin
							end
						endcase
					end
					// end of scan: failure codes and next state
					if (finish) begin
						if (!stop_hit) begin
							case (cmd_q)
								CMD_REQUEST: res_status_q <= RS_NO_FREE;
								CMD_LOAD_NEXT, CMD_GET: res_status_q <= RS_NO_MATCH;
								CMD_FLUSH: begin
									if (!(found_q || chk.hit)) begin
										res_status_q <= RS_NO_MATCH;
									end
								end
								default: begin
								end
							endcase
						end
						state_q <= (stop_hit && cmd_q == CMD_GET) ? S_FIN : S_RESP;
					end
				end
				S_FIN: begin
					// get grants min(requested, remaining)
					if (size_q < res_length_q) begin
						res_length_q <= size_q;
					end
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`SPS_ASSERT_NEXT(a_busy_after_accept, req.valid && req.ready, !req.ready, "ready after accept")
	`SPS_ASSERT(a_check_in_scan, !chk_vld_s1 || (state_q == S_SCAN), "check outside scan")
	`SPS_ASSERT(a_scan_bound, scan_q <= CNT_W'(SLOTS), "scan index past table")
	`SPS_ASSERT_NEXT(a_fin_to_resp, state_q == S_FIN, rsp.valid, "get result not presented")

endmodule

@@ design/sps_slot_check.sv @@
// Shared per-slot compare unit: decides whether one slot matches the command.
module sps_slot_check (
	input  sps_pkg::cmd_t    cmd,
	input  sps_pkg::pos_t    position,
	input  sps_pkg::sstate_t st,
	input  sps_pkg::pos_t    slot_pos,
	input  sps_pkg::len_t    slot_size,
	output sps_pkg::chk_t    res
);
	import sps_pkg::*;

	logic [32:0] diff;
	logic        in_range;

	// position relative to slot start; range end is inclusive, no wrap
	always_comb begin
		diff     = {1'b0, position} - {1'b0, slot_pos};
		in_range = !diff[32] && (diff[31:24] == 8'd0) && (diff[23:0] <= slot_size);
		res.offset = diff[23:0];
		res.remain = slot_size - diff[23:0];
		case (cmd)
			CMD_REQUEST:   res.hit = (st == SL_FREE);
			CMD_LOAD_NEXT: res.hit = (st == SL_WAIT);
			CMD_GET:       res.hit = (st == SL_LOADED) && in_range;
			CMD_FLUSH:     res.hit = (st != SL_FREE) && (slot_pos == position);
			CMD_STATUS:    res.hit = (st == SL_LOADED);
			default:       res.hit = 1'b0;
		endcase
	end
endmodule

@@ tb/sv/sps_tb_pkg.sv @@
// Slot table tracker: predicts each result of the prefetch slot table and checks the block's.
`timescale 1ns / 100ps
package sps_tb_pkg;
	import sps_pkg::*;

	localparam int NSLOTS = 8;

	// codes the block does not define
	localparam cmd_t CMD_UNUSED_6 = 3'd6;
	localparam cmd_t CMD_UNUSED_7 = 3'd7;

	localparam pos_t POS_NONE = 32'hFFFF_FFFF;

	typedef struct packed {
		rstat_t     status;
		logic [2:0] slot;
		len_t       offset;
		len_t       length;
		pos_t       position_out;
		logic       clamped;
	} slot_answer_t;

	class slot_table_tracker;
		sstate_t      slot_state [NSLOTS];
		pos_t         slot_pos [NSLOTS];
		len_t         slot_len [NSLOTS];
		len_t         size_limit;
		slot_answer_t expected_answers [$];
		int           mismatches;

		function new();
			size_limit = MAX_SIZE_RESET;
			mismatches = 0;
			clear_slots();
		endfunction

		function void clear_slots();
			for (int i = 0; i < NSLOTS; i++) begin
				slot_state[i] = SL_FREE;
				slot_pos[i] = '0;
				slot_len[i] = '0;
			end
		endfunction

		function int outstanding();
			return expected_answers.size();
		endfunction

		// random slot that is loaded, or just not free; 0 when there is none
		function bit pick_slot(input bit loaded_only, output pos_t p, output len_t span);
			int cands [$];
			int k;
			p = '0;
			span = '0;
			for (int i = 0; i < NSLOTS; i++) begin
				if (loaded_only ? (slot_state[i] == SL_LOADED) : (slot_state[i] != SL_FREE))
					cands.push_back(i);
			end
			if (cands.size() == 0)
				return 1'b0;
			k = cands[$urandom_range(0, cands.size() - 1)];
			p = slot_pos[k];
			span = slot_len[k];
			return 1'b1;
		endfunction

		// work out the result of one accepted command and update the slot copy
		function void note_command(cmd_t c, pos_t p, len_t s, logic [2:0] idx);
			slot_answer_t a;
			logic [32:0]  span_end;
			logic [32:0]  remain;
			pos_t         diff;
			int           k;
			a = '0;
			k = -1;
			case (c)
				CMD_REQUEST: begin
					if (s == 0 || p == 0 || p == POS_NONE) begin
						a.status = RS_REJECT;
					end else begin
						for (int i = 0; i < NSLOTS; i++)
							if (k < 0 && slot_state[i] == SL_FREE) k = i;
						if (k < 0) begin
							a.status = RS_NO_FREE;
						end else begin
							// sizes above the limit are cut, a zero limit cuts all to 0
							if (s > size_limit) begin
								s = size_limit;
								a.clamped = 1'b1;
							end
							slot_state[k] = SL_WAIT;
							slot_pos[k] = p;
							slot_len[k] = s;
							a.status = RS_OK;
							a.slot = k[2:0];
							a.length = s;
						end
					end
				end
				CMD_LOAD_NEXT: begin
					for (int i = 0; i < NSLOTS; i++)
						if (k < 0 && slot_state[i] == SL_WAIT) k = i;
					if (k < 0) begin
						a.status = RS_NO_MATCH;
					end else begin
						slot_state[k] = SL_LOADED;
						a.status = RS_OK;
						a.slot = k[2:0];
						a.length = slot_len[k];
						a.position_out = slot_pos[k];
					end
				end
				CMD_GET: begin
					if (p == 0) begin
						a.status = RS_REJECT;
					end else begin
						// inclusive range, end computed without wrap
						for (int i = 0; i < NSLOTS; i++) begin
							span_end = {1'b0, slot_pos[i]} + {9'd0, slot_len[i]};
							if (k < 0 && slot_state[i] == SL_LOADED && p >= slot_pos[i] &&
									{1'b0, p} <= span_end)
								k = i;
						end
						if (k < 0) begin
							a.status = RS_NO_MATCH;
						end else begin
							span_end = {1'b0, slot_pos[k]} + {9'd0, slot_len[k]};
							remain = span_end - {1'b0, p};
							diff = p - slot_pos[k];
							a.status = RS_OK;
							a.slot = k[2:0];
							a.offset = diff[23:0];
							a.length = ({9'd0, s} < remain) ? s : remain[23:0];
							slot_state[k] = SL_FREE;
							slot_pos[k] = '0;
						end
					end
				end
				CMD_FLUSH: begin
					if (p == 0 || p == POS_NONE) begin
						a.status = RS_REJECT;
					end else begin
						// every slot at that position goes, the lowest one is reported
						a.status = RS_NO_MATCH;
						for (int i = NSLOTS - 1; i >= 0; i--) begin
							if (slot_pos[i] == p) begin
								slot_state[i] = SL_FREE;
								slot_pos[i] = '0;
								a.slot = i[2:0];
								a.status = RS_OK;
							end
						end
					end
				end
				CMD_FLUSH_ALL: begin
					clear_slots();
					a.status = RS_OK;
				end
				CMD_STATUS: begin
					a.slot = idx;
					if (idx >= NSLOTS)
						a.status = RS_REJECT;
					else if (slot_state[idx] == SL_LOADED)
						a.position_out = slot_pos[idx];
				end
				default: begin
					a.status = RS_REJECT;
				end
			endcase
			expected_answers.push_back(a);
		endfunction

		// compare one accepted result with the oldest prediction
		function void check_result(slot_answer_t got);
			slot_answer_t want;
			if (expected_answers.size() == 0) begin
				$error("result with no command pending: status %0d slot %0d",
					got.status, got.slot);
				mismatches++;
				return;
			end
			want = expected_answers.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				mismatches++;
			end
			if (got.slot !== want.slot) begin
				$error("slot: expected %0d, got %0d", want.slot, got.slot);
				mismatches++;
			end
			if (got.offset !== want.offset) begin
				$error("offset: expected %h, got %h", want.offset, got.offset);
				mismatches++;
			end
			if (got.length !== want.length) begin
				$error("length: expected %h, got %h", want.length, got.length);
				mismatches++;
			end
			if (got.position_out !== want.position_out) begin
				$error("position_out: expected %h, got %h", want.position_out,
					got.position_out);
				mismatches++;
			end
			if (got.clamped !== want.clamped) begin
				$error("clamped: expected %0b, got %0b", want.clamped, got.clamped);
				mismatches++;
			end
		endfunction
	endclass

endpackage

@@ tb/sv/stream_prefetch_slot_table_tb.sv @@
// Top testbench of the stream prefetch slot table: stimulus, backpressure and end of run.
`timescale 1ns / 100ps
module stream_prefetch_slot_table_tb;
	import sps_pkg::*;
	import sps_tb_pkg::*;

	localparam int CYCLE_LIMIT  = 500000;
	localparam int LONG_HOLD    = 300;
	localparam int PHASE_ITEMS  = 180;
	localparam int DRAIN_CYCLES = 20;

	logic clk;
	logic arst_n;
	logic cfg_we;
	len_t cfg_wdata;

	sps_req_if req_ch();
	sps_rsp_if rsp_ch();

	slot_table_tracker tracker;
	bit quiet = 1'b0;
	int hold_asks = 0;
	int holds_done = 0;
	int cycle_count = 0;

	stream_prefetch_slot_table #(.SLOTS(NSLOTS)) dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.req       (req_ch),
		.rsp       (rsp_ch)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("stream_prefetch_slot_table: mismatch");
			$finish;
		end
	end

	// result side: random stall bursts, and a long hold when asked
	initial begin
		int gap;
		rsp_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_asks != holds_done) begin
				rsp_ch.ready <= 1'b0;
				repeat (LONG_HOLD - 1) @(negedge clk);
				holds_done++;
			end else if (!quiet && $urandom_range(0, 5) == 0) begin
				gap = $urandom_range(1, 9);
				rsp_ch.ready <= 1'b0;
				repeat (gap - 1) @(negedge clk);
			end else begin
				rsp_ch.ready <= 1'b1;
			end
		end
	end

	// take each result
	always @(posedge clk) begin : take_result
		slot_answer_t got;
		if (arst_n && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
			got.status = rsp_ch.status;
			got.slot = rsp_ch.slot;
			got.offset = rsp_ch.offset;
			got.length = rsp_ch.length;
			got.position_out = rsp_ch.position_out;
			got.clamped = rsp_ch.clamped;
			tracker.check_result(got);
		end
	end

	// offer one command, possibly after an idle burst; returns at a falling edge
	task automatic send_cmd(input cmd_t c, input pos_t p, input len_t s,
			input logic [2:0] idx);
		int gap;
		if (!quiet && $urandom_range(0, 4) == 0) begin
			gap = $urandom_range(1, 9);
			req_ch.valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.cmd <= c;
		req_ch.position <= p;
		req_ch.size <= s;
		req_ch.slot_index <= idx;
		@(posedge clk);
		while (req_ch.ready !== 1'b1) @(posedge clk);
		tracker.note_command(c, p, s, idx);
		@(negedge clk);
	endtask

	// stop offering and wait for every pending result
	task automatic go_idle();
		req_ch.valid <= 1'b0;
		while (tracker.outstanding() != 0) @(negedge clk);
	endtask

	task automatic write_limit(input len_t v);
		go_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		tracker.size_limit = v;
	endtask

	// positions: a small pool that repeats, full random, near the top, and the rejected ends
	function automatic pos_t pool_position();
		int r;
		r = $urandom_range(0, 19);
		if (r < 10)
			return 32'h1000 * $urandom_range(1, 12);
		else if (r < 15)
			return $urandom;
		else if (r < 17)
			return 32'hFFFF_FF00 | $urandom_range(0, 255);
		else if (r == 17)
			return '0;
		else if (r == 18)
			return POS_NONE;
		else
			return 32'h1000 * $urandom_range(1, 12) + $urandom_range(1, 64);
	endfunction

	function automatic len_t request_size();
		int r;
		r = $urandom_range(0, 9);
		if (r < 4)
			return len_t'($urandom_range(1, 64));
		else if (r < 6)
			return len_t'($urandom_range(1, 24'h20000));
		else if (r < 8)
			return len_t'($urandom);
		else if (r == 8)
			return '0;
		else
			return 24'hFF_FFFF;
	endfunction

	// one random command; get and flush are mostly aimed at slots that exist
	task automatic send_random_cmd();
		int   pick;
		bit   have;
		cmd_t c;
		pos_t p;
		len_t s;
		len_t span;
		logic [2:0] idx;
		pick = $urandom_range(0, 99);
		p = $urandom;
		s = len_t'($urandom);
		idx = 3'($urandom_range(0, 7));
		if (pick < 28) begin
			c = CMD_REQUEST;
			p = pool_position();
			s = request_size();
		end else if (pick < 44) begin
			c = CMD_LOAD_NEXT;
		end else if (pick < 70) begin
			c = CMD_GET;
			have = tracker.pick_slot(1'b1, p, span);
			if (have && $urandom_range(0, 9) < 8) begin
				// inside the range, at its ends, or just outside
				case ($urandom_range(0, 9))
					0: p = p + span;
					1: p = p + span + 1;
					2: p = p - 1;
					default: p = p + $urandom_range(0, span);
				endcase
			end else begin
				p = pool_position();
			end
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4: s = len_t'($urandom_range(0, 512));
				5, 6, 7: s = len_t'($urandom);
				8: s = '0;
				default: s = 24'hFF_FFFF;
			endcase
		end else if (pick < 80) begin
			c = CMD_FLUSH;
			have = tracker.pick_slot(1'b0, p, span);
			if (!have || $urandom_range(0, 3) == 0)
				p = pool_position();
		end else if (pick < 83) begin
			c = CMD_FLUSH_ALL;
		end else if (pick < 96) begin
			c = CMD_STATUS;
		end else begin
			c = $urandom_range(0, 1) ? CMD_UNUSED_6 : CMD_UNUSED_7;
		end
		send_cmd(c, p, s, idx);
	endtask

	// main sequence
	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.cmd = CMD_STATUS;
		req_ch.position = '0;
		req_ch.size = '0;
		req_ch.slot_index = '0;
		tracker = new();
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed: empty table, rejected arguments, clamp, end of range, full table
		send_cmd(CMD_LOAD_NEXT, '0, '0, '0);
		send_cmd(CMD_REQUEST, '0, 24'd10, '0);
		send_cmd(CMD_REQUEST, POS_NONE, 24'd10, '0);
		send_cmd(CMD_REQUEST, 32'h1000, '0, '0);
		send_cmd(CMD_REQUEST, 32'h1000, 24'hFF_FFFF, '0);
		send_cmd(CMD_REQUEST, 32'hFFFF_FFF0, 24'h00_FFFF, '0);
		send_cmd(CMD_LOAD_NEXT, '0, '0, '0);
		send_cmd(CMD_LOAD_NEXT, '0, '0, '0);
		send_cmd(CMD_STATUS, '0, '0, 3'd0);
		send_cmd(CMD_GET, '0, 24'd16, '0);
		send_cmd(CMD_GET, 32'h1000 + 32'h1_0000, 24'hFF_FFFF, '0);
		send_cmd(CMD_GET, POS_NONE, 24'hFF_FFFF, '0);
		send_cmd(CMD_FLUSH, '0, '0, '0);
		send_cmd(CMD_FLUSH, POS_NONE, '0, '0);
		for (int i = 0; i <= NSLOTS; i++)
			send_cmd(CMD_REQUEST, 32'h5000, len_t'(i + 1), '0);
		send_cmd(CMD_LOAD_NEXT, '0, '0, '0);
		send_cmd(CMD_FLUSH_ALL, '0, '0, '0);
		send_cmd(CMD_FLUSH, 32'h5000, '0, '0);
		send_cmd(CMD_UNUSED_6, 32'h1000, 24'd1, 3'd1);
		send_cmd(CMD_UNUSED_7, 32'h1000, 24'd1, 3'd1);

		// random phases over several size limits; the last one runs without idling
		for (int ph = 0; ph < 5; ph++) begin
			case (ph)
				1: write_limit('0);
				2: write_limit(24'd1);
				3: write_limit(24'hFF_FFFF);
				4: write_limit(len_t'($urandom_range(2, 24'h3_0000)));
				default: ;
			endcase
			if (ph == 2 || ph == 3)
				hold_asks++;
			if (ph == 4)
				quiet = 1'b1;
			repeat (PHASE_ITEMS) send_random_cmd();
		end

		go_idle();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.mismatches == 0 && tracker.outstanding() == 0)
			$display("stream_prefetch_slot_table: match");
		else
			$display("stream_prefetch_slot_table: mismatch");
		$finish;
	end

endmodule
